@@ hw/rtl/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared widths and beat types for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CpW   = 31;  // code point width
  localparam int unsigned LeftW = 3;   // continuation bytes still expected
  localparam int unsigned ContW = 6;   // value bits per continuation byte

  // One result beat
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_error;
  } utf8sd_result_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [LeftW-1:0] bytes_left;
    logic [CpW-1:0]   partial;
  } utf8sd_state_t;

  // What one byte produces
  typedef struct packed {
    logic           emit;
    utf8sd_result_t result;
  } utf8sd_step_t;

endpackage

@@ hw/rtl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial decoder for the original six-byte UTF-8 form.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the input is not stalled. A byte
// that completes a sequence, or that breaks one, yields a result beat in the
// output register, or in the skid register while the output is stalled; lead
// and middle continuation bytes yield none. The decoder state (bytes left and
// the partial value) is registered on each accepted byte. A two-entry output
// stage (output register plus skid register) lets the input keep flowing while
// one result waits; the input stalls only when both entries are full.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] code_point_o,
  output logic        is_error_o
);
  import utf8sd_pkg::*;

  utf8sd_state_t  state_q, state_d;
  utf8sd_step_t   step;
  utf8sd_result_t out_q, out_d, skid_q, skid_d;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  logic           in_fire, out_free, res_valid;

  utf8sd_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_i),
    .state_o (state_d),
    .step_o  (step)
  );

  assign in_fire   = in_valid_i & ~skid_valid_q;
  assign res_valid = in_fire & step.emit;
  assign out_free  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step.result;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      // hold the stalled beat, park the new one
      skid_d       = step.result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_q.code_point;
  assign is_error_o   = out_q.is_error;

endmodule

@@ hw/rtl/utf8sd_decode.sv @@
// ----------------------------------------------------------------------------
// utf8sd_decode
// Single-byte state update: classifies lead and continuation bytes and
// forms the next state and an optional result beat.
// ----------------------------------------------------------------------------
module utf8sd_decode (
  input  utf8sd_pkg::utf8sd_state_t state_i,
  input  logic [7:0]                byte_i,
  output utf8sd_pkg::utf8sd_state_t state_o,
  output utf8sd_pkg::utf8sd_step_t  step_o
);
  import utf8sd_pkg::*;

  logic [CpW-1:0] shifted;

  assign shifted = {state_i.partial[CpW-ContW-1:0], byte_i[ContW-1:0]};

  always_comb begin
    state_o                  = state_i;
    step_o.emit              = 1'b0;
    step_o.result.code_point = '0;
    step_o.result.is_error   = 1'b0;

    if (state_i.bytes_left == '0) begin
      if (byte_i[7] == 1'b0) begin
        step_o.emit              = 1'b1;
        step_o.result.code_point = CpW'(byte_i[6:0]);
      end else if (byte_i[7:5] == 3'b110) begin
        state_o.partial    = CpW'(byte_i[4:0]);
        state_o.bytes_left = LeftW'(1);
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.partial    = CpW'(byte_i[3:0]);
        state_o.bytes_left = LeftW'(2);
      end else if (byte_i[7:3] == 5'b11110) begin
        state_o.partial    = CpW'(byte_i[2:0]);
        state_o.bytes_left = LeftW'(3);
      end else if (byte_i[7:2] == 6'b111110) begin
        state_o.partial    = CpW'(byte_i[1:0]);
        state_o.bytes_left = LeftW'(4);
      end else if (byte_i[7:1] == 7'b1111110) begin
        state_o.partial    = CpW'(byte_i[0]);
        state_o.bytes_left = LeftW'(5);
      end else begin
        // stray continuation or 0xFE / 0xFF lead
        state_o.partial        = '0;
        step_o.emit            = 1'b1;
        step_o.result.is_error = 1'b1;
      end
    end else if (byte_i[7:6] != 2'b10) begin
      // drop the broken sequence and consume this byte
      state_o.bytes_left     = '0;
      state_o.partial        = '0;
      step_o.emit            = 1'b1;
      step_o.result.is_error = 1'b1;
    end else begin
      state_o.bytes_left = state_i.bytes_left - LeftW'(1);
      state_o.partial    = shifted;
      if (state_i.bytes_left == LeftW'(1)) begin
        state_o.partial          = '0;
        step_o.emit              = 1'b1;
        step_o.result.code_point = shifted;
      end
    end
  end

endmodule

@@ hw/rtl/utf8sd_checker.sv @@
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8sd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [30:0] code_point_o,
  input logic        is_error_o
);

  // An error beat never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_error_o |-> code_point_o == 31'd0)
    else $error("error beat with nonzero code point");

  // 0xFE and 0xFF are errors in any state, so a beat must be waiting next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_byte_i[7:1] == 7'b1111111 |=> out_valid_o)
    else $error("invalid lead byte produced no result");

  // The input stalls only when the output side is backed up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(code_point_o) && $stable(is_error_o))
    else $error("stalled result beat changed");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .in_byte_i    (in_byte_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_point_o (code_point_o),
  .is_error_o   (is_error_o)
);

@@ tb/utf8_stream_decoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Self-checking testbench for the byte-serial UTF-8 decoder. Bytes are sent
// through the valid/stall input with random gaps, and each one is run through
// a local decoder model that queues the code point or error beat it causes.
// A checker pops that queue for every result beat while it stalls the output
// at random.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;
  import utf8sd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [7:0]     in_byte = 8'h00;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [CpW-1:0] code_point;
  logic           is_error;

  // decoder model state
  logic [LeftW-1:0] left_cnt = '0;
  logic [CpW-1:0]   partial_acc = '0;

  utf8sd_result_t expected_cp_q[$];

  int fail_cnt      = 0;
  int items_sent    = 0;
  int out_beats     = 0;
  int err_beats     = 0;
  int send_gap_pct  = 20;
  int out_stall_pct = 20;
  int idle_cycles   = 0;

  utf8_stream_decoder i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .code_point_o (code_point),
    .is_error_o   (is_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the model by one byte; return the beat it causes, if any.
  function automatic utf8sd_step_t decode_byte(input logic [7:0] b);
    utf8sd_step_t step;
    step = '0;
    if (left_cnt == '0) begin
      if (b[7] == 1'b0) begin
        step.emit = 1'b1;
        step.result.code_point = CpW'(b[6:0]);
      end else if (b[7:5] == 3'b110) begin
        partial_acc = CpW'(b[4:0]);
        left_cnt = LeftW'(1);
      end else if (b[7:4] == 4'b1110) begin
        partial_acc = CpW'(b[3:0]);
        left_cnt = LeftW'(2);
      end else if (b[7:3] == 5'b11110) begin
        partial_acc = CpW'(b[2:0]);
        left_cnt = LeftW'(3);
      end else if (b[7:2] == 6'b111110) begin
        partial_acc = CpW'(b[1:0]);
        left_cnt = LeftW'(4);
      end else if (b[7:1] == 7'b1111110) begin
        partial_acc = CpW'(b[0]);
        left_cnt = LeftW'(5);
      end else begin
        // stray continuation or 0xFE/0xFF as lead
        partial_acc = '0;
        step.emit = 1'b1;
        step.result.is_error = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      // drop the open sequence; the offending byte is consumed
      left_cnt = '0;
      partial_acc = '0;
      step.emit = 1'b1;
      step.result.is_error = 1'b1;
    end else begin
      partial_acc = {partial_acc[CpW-ContW-1:0], b[ContW-1:0]};
      left_cnt = left_cnt - LeftW'(1);
      if (left_cnt == '0) begin
        step.emit = 1'b1;
        step.result.code_point = partial_acc;
        partial_acc = '0;
      end
    end
    return step;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] lead_for(input int n);
    case (n)
      1:       return 8'($urandom_range(0, 127));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      4:       return 8'hF0 | 8'($urandom_range(0, 7));
      5:       return 8'hF8 | 8'($urandom_range(0, 3));
      default: return 8'hFC | 8'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Send one byte beat; valid stays high on return so back-to-back beats flow.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    utf8sd_step_t step;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    step = decode_byte(b);
    if (step.emit) expected_cp_q.push_back(step.result);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_cp_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_sequence(input int n);
    push_byte(lead_for(n));
    for (int i = 1; i < n; i++) push_byte(cont_byte());
  endtask

  // Lead, k continuations, then a byte that is not a continuation.
  task automatic send_broken(input int n, input int k);
    int b;
    push_byte(lead_for(n));
    repeat (k) push_byte(cont_byte());
    b = $urandom_range(0, 191);
    if (b >= 128) b += 64;
    push_byte(8'(b));
  endtask

  task automatic test_single_byte();
    push_byte(8'h00);
    push_byte(8'h7F);
  endtask

  task automatic test_sequences();
    push_byte(8'hC0); push_byte(8'h80);
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hF0); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'hFB);
    repeat (4) push_byte(8'hBF);
    // six bytes fill all 31 code point bits
    push_byte(8'hFD);
    repeat (5) push_byte(8'hBF);
  endtask

  task automatic test_bad_lead();
    push_byte(8'h80);
    push_byte(8'hFE);
  endtask

  task automatic test_broken_sequence();
    push_byte(8'hC2);
    push_byte(8'hFF);
  endtask

  // Hold the sender inside an open sequence until the output is empty.
  task automatic test_hold_mid_sequence();
    push_byte(8'hE2);
    push_byte(8'h82);
    drain_results();
    push_byte(8'hAC);
  endtask

  task automatic test_random_stream();
    int target;
    int pick;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 30; out_stall_pct = 30; end
        1: begin send_gap_pct = 0;  out_stall_pct = 0;  end
        2: begin send_gap_pct = 60; out_stall_pct = 10; end
        default: begin send_gap_pct = 10; out_stall_pct = 60; end
      endcase
      target = items_sent + 312;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_sequence($urandom_range(1, 6));
        end else if (pick < 87) begin
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(2, 6);
          send_broken(len, $urandom_range(0, len - 2));
        end
      end
    end
  endtask

  initial begin : result_check
    utf8sd_result_t exp_res;
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        out_beats++;
        if (is_error) err_beats++;
        if (expected_cp_q.size() == 0) begin
          $display("%0t: unexpected beat code_point=%h is_error=%b",
                   $time, code_point, is_error);
          fail_cnt++;
        end else begin
          exp_res = expected_cp_q.pop_front();
          if (code_point !== exp_res.code_point) begin
            $display("%0t: code_point expected %h actual %h",
                     $time, exp_res.code_point, code_point);
            fail_cnt++;
          end
          if (is_error !== exp_res.is_error) begin
            $display("%0t: is_error expected %b actual %b",
                     $time, exp_res.is_error, is_error);
            fail_cnt++;
          end
        end
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < out_stall_pct) stall_run = pick_gap();
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_n);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte();
    test_sequences();
    test_bad_lead();
    test_broken_sequence();
    test_hold_mid_sequence();
    test_random_stream();
    drain_results();
    $display("covered %0d byte beats and %0d result beats (%0d errors)",
             items_sent, out_beats, err_beats);
    $display("one- to six-byte, broken and invalid sequences under idle and stall gaps");
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_decode.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/utf8sd_checker.sv
tb/utf8_stream_decoder_test.sv
